// ----- design/toeq_pkg.sv -----
`timescale 1ns / 1ps
// types and constants shared by the event queue cells, controller and top level
// no dependencies

package toeq_pkg;

   localparam int DEPTH_DEF = 16;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_TICK   = 1'b1;
   localparam logic KIND_ACK    = 1'b0;
   localparam logic KIND_FIRE   = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [7:0]  event_id;
      logic [31:0] start_time;
      logic [31:0] end_time;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic       status;
      logic [7:0] fired_id;
      logic       retired;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  event_id;
      logic [31:0] start_time;
      logic [31:0] end_time;
   } entry_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic        insert_en;
      logic        rotate_en;
      logic        keep;
      entry_type   new_entry;
      logic [31:0] now;
   } chain_cmd_type;

   typedef struct packed {
      logic gt;
      logic due;
      logic ret;
   } cell_flags_type;

   // what the controller sees of the head of the chain
   typedef struct packed {
      logic       head_due;
      logic       head_ret;
      logic       next_due;
      logic [7:0] head_id;
   } chain_stat_type;

endpackage

// ----- design/toeq_cell.sv -----
`timescale 1ns / 1ps
// one slot of the sorted event chain: holds an entry, takes from either neighbour
// depends on toeq_pkg

module toeq_cell
   import toeq_pkg::*;
(
   input  logic           clock,
   input  chain_cmd_type  cmd,
   input  logic           occupied,
   input  logic           is_tail,
   input  logic           left_gt,
   input  entry_type      left_entry,
   input  entry_type      right_entry,
   input  entry_type      head_entry,
   output entry_type      entry,
   output cell_flags_type flags
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      // empty slots count as later than anything, so they take part in the shift
      flags.gt  = !occupied || (entry_ff.start_time > cmd.new_entry.start_time);
      flags.due = entry_ff.start_time <= cmd.now;
      flags.ret = entry_ff.end_time <= cmd.now;
   end

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert_en) begin
         if (flags.gt) begin
            entry_in = left_gt ? left_entry : cmd.new_entry;
         end
      end else if (cmd.rotate_en) begin
         // the kept head wraps round to the last occupied slot
         entry_in = (cmd.keep && is_tail) ? head_entry : right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ----- design/toeq_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer for inserts and tick walks, occupancy count and result register
// depends on toeq_pkg

module toeq_ctrl
   import toeq_pkg::*;
#(
   parameter int  DEPTH = DEPTH_DEF,
   localparam int OCC_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  req_type          req_data,
   output logic             req_stall,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             rsp_stall,
   input  chain_stat_type   stat,
   output chain_cmd_type    cmd,
   output logic [OCC_W-1:0] occupancy
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_INSERT = 3'b010,
      ST_WALK   = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [OCC_W-1:0] rem_ff, rem_in;
   logic             walking_ff, walking_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic req_take;
   logic rsp_free;
   logic full;
   logic emit;
   logic fire_last;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign full      = (occ_ff == OCC_W'(DEPTH));
   assign fire_last = (rem_ff == OCC_W'(1)) || !stat.next_due;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      occ_in       = occ_ff;
      rem_in       = rem_ff;
      walking_in   = walking_ff;
      emit         = 1'b0;
      rsp_data_in  = rsp_data_ff;
      cmd.insert_en = 1'b0;
      cmd.rotate_en = 1'b0;
      cmd.keep      = 1'b1;
      cmd.new_entry.event_id   = req_ff.event_id;
      cmd.new_entry.start_time = req_ff.start_time;
      cmd.new_entry.end_time   = req_ff.end_time;
      cmd.now       = req_ff.now;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               req_in     = req_data;
               rem_in     = occ_ff;
               walking_in = 1'b1;
               state_in   = (req_data.mode == MODE_TICK) ? ST_WALK : ST_INSERT;
            end
         end
         ST_INSERT: begin
            if (rsp_free) begin
               emit = 1'b1;
               rsp_data_in.kind     = KIND_ACK;
               rsp_data_in.status   = full ? STATUS_FULL : STATUS_OK;
               rsp_data_in.fired_id = '0;
               rsp_data_in.retired  = 1'b0;
               rsp_data_in.last     = 1'b1;
               if (!full) begin
                  cmd.insert_en = 1'b1;
                  occ_in        = occ_ff + OCC_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (rem_ff == '0) begin
               state_in = ST_IDLE;
            end else if (walking_ff && stat.head_due) begin
               if (rsp_free) begin
                  emit = 1'b1;
                  rsp_data_in.kind     = KIND_FIRE;
                  rsp_data_in.status   = STATUS_OK;
                  rsp_data_in.fired_id = stat.head_id;
                  rsp_data_in.retired  = stat.head_ret;
                  rsp_data_in.last     = fire_last;
                  cmd.rotate_en = 1'b1;
                  cmd.keep      = !stat.head_ret;
                  if (stat.head_ret) begin
                     occ_in = occ_ff - OCC_W'(1);
                  end
                  rem_in     = rem_ff - OCC_W'(1);
                  walking_in = !fire_last;
               end
            end else begin
               // past the due prefix: keep rotating to restore the original order
               cmd.rotate_en = 1'b1;
               rem_in        = rem_ff - OCC_W'(1);
               walking_in    = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rem_ff       <= '0;
         walking_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rem_ff       <= rem_in;
         walking_ff   <= walking_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign occupancy = occ_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(DEPTH))
      else $error("occupancy above depth");

   a_walk_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && rem_ff == '0) |=> (state_ff == ST_IDLE))
      else $error("walk did not finish with nothing left to visit");

   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && emit && fire_last) |=> !walking_ff)
      else $error("walk still firing after the last beat");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT && full && rsp_free) |=> $stable(occ_ff))
      else $error("rejected insert changed occupancy");

endmodule

// ----- design/time_ordered_event_queue.sv -----
`timescale 1ns / 1ps
// time ordered event queue: sorted chain of entry cells plus the sequencer
// depends on toeq_pkg, toeq_cell, toeq_ctrl
//
//   channel  direction  payload   handshake
//   req_     in         req_type  req_valid / req_stall
//   rsp_     out        rsp_type  rsp_valid / rsp_stall
//
// an insert is taken on its accept beat; once the result register is free, every
// cell compares and shifts at once and the acknowledgement is registered.
// a tick is taken on its accept beat; then, for each stored event, the chain
// rotates one slot past the head, firing due entries and dropping retired ones,
// and a last step with nothing left to visit closes the walk.
// reset clears the sequencer and the occupancy count; slot contents need no clearing.
// a stalled result beat holds the walk at the head until it drains.

module time_ordered_event_queue
   import toeq_pkg::*;
#(
   parameter int  DEPTH = DEPTH_DEF,
   localparam int OCC_W = $clog2(DEPTH + 1)
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   chain_cmd_type    cmd;
   chain_stat_type   stat;
   logic [OCC_W-1:0] occupancy;

   entry_type      cell_entry [DEPTH];
   cell_flags_type cell_flags [DEPTH];

   toeq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd),
      .occupancy (occupancy)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      left_gt;
      entry_type left_entry;
      entry_type right_entry;

      if (i == 0) begin : g_first
         assign left_gt    = 1'b0;
         assign left_entry = cell_entry[i];
      end else begin : g_mid
         assign left_gt    = cell_flags[i-1].gt;
         assign left_entry = cell_entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      toeq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (occupancy > OCC_W'(i)),
         .is_tail     (occupancy == OCC_W'(i + 1)),
         .left_gt     (left_gt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .head_entry  (cell_entry[0]),
         .entry       (cell_entry[i]),
         .flags       (cell_flags[i])
      );
   end

   assign stat.head_due = cell_flags[0].due;
   assign stat.head_ret = cell_flags[0].ret;
   assign stat.next_due = cell_flags[1].due;
   assign stat.head_id  = cell_entry[0].event_id;

endmodule

// ----- dv/time_ordered_event_queue_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for time_ordered_event_queue: a directed start, then random inserts and ticks
// under several idle and stall patterns, with a shadow of the sorted store predicting every beat
// depends on toeq_pkg and time_ordered_event_queue

module time_ordered_event_queue_tb;
   import toeq_pkg::*;

   localparam int DEPTH          = DEPTH_DEF;
   localparam int QUIET_LIMIT    = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 60;
   localparam int REPORT_MAX     = 10;
   localparam int RANDOM_PER_SET = 85;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    rsp_stall = 1'b0;

   time_ordered_event_queue #(.DEPTH(DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow of the sorted store
   logic [31:0] shadow_start [DEPTH];
   logic [31:0] shadow_end   [DEPTH];
   logic [7:0]  shadow_id    [DEPTH];
   int          shadow_count = 0;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];

   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   bit          pressure_on    = 1'b0;
   bit          hold_done      = 1'b0;
   int          hold_left      = 0;
   int          mismatches     = 0;
   int          quiet_cycles   = 0;
   logic [31:0] time_base      = 32'd0;

   // insert or tick applied to the shadow store, expected beats appended
   task automatic apply_to_shadow(input req_type r);
      int      pos;
      int      w;
      int      fired;
      bit      walking;
      bit      keep;
      bit      gone;
      rsp_type beat;
      beat = '0;
      if (r.mode == MODE_INSERT) begin
         beat.kind = KIND_ACK;
         beat.last = 1'b1;
         if (shadow_count >= DEPTH) begin
            beat.status = STATUS_FULL;
         end else begin
            pos = shadow_count;
            while (pos > 0 && shadow_start[pos-1] > r.start_time) pos--;
            for (int i = shadow_count; i > pos; i--) begin
               shadow_start[i] = shadow_start[i-1];
               shadow_end[i]   = shadow_end[i-1];
               shadow_id[i]    = shadow_id[i-1];
            end
            shadow_start[pos] = r.start_time;
            shadow_end[pos]   = r.end_time;
            shadow_id[pos]    = r.event_id;
            shadow_count++;
            beat.status = STATUS_OK;
         end
         expected_rsps = {expected_rsps, beat};
      end else begin
         w = 0;
         fired = 0;
         walking = 1'b1;
         for (int i = 0; i < shadow_count; i++) begin
            keep = 1'b1;
            if (walking && shadow_start[i] <= r.now) begin
               gone = (shadow_end[i] <= r.now);
               beat.kind     = KIND_FIRE;
               beat.status   = STATUS_OK;
               beat.fired_id = shadow_id[i];
               beat.retired  = gone;
               beat.last     = 1'b0;
               expected_rsps = {expected_rsps, beat};
               fired++;
               if (gone) keep = 1'b0;
            end else begin
               walking = 1'b0;
            end
            if (keep) begin
               shadow_start[w] = shadow_start[i];
               shadow_end[w]   = shadow_end[i];
               shadow_id[w]    = shadow_id[i];
               w++;
            end
         end
         shadow_count = w;
         if (fired > 0) begin
            beat = expected_rsps.pop_back();
            beat.last = 1'b1;
            expected_rsps = {expected_rsps, beat};
         end
      end
   endtask

   task automatic add_insert(input logic [7:0] id, input logic [31:0] st, input logic [31:0] en);
      req_type r;
      r.mode       = MODE_INSERT;
      r.event_id   = id;
      r.start_time = st;
      r.end_time   = en;
      r.now        = $urandom;
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic add_tick(input logic [31:0] at);
      req_type r;
      r.mode       = MODE_TICK;
      r.event_id   = 8'($urandom);
      r.start_time = $urandom;
      r.end_time   = $urandom;
      r.now        = at;
      pending_reqs = {pending_reqs, r};
   endtask

   // mostly well-formed traffic around a moving clock, with some pure noise
   task automatic add_random_item();
      int          pick;
      logic [31:0] st;
      logic [31:0] en;
      req_type     r;
      pick = $urandom_range(99);
      if (pick < 50) begin
         if ($urandom_range(7) == 0) st = time_base - $urandom_range(0, 100);
         else st = time_base + $urandom_range(0, 300);
         case ($urandom_range(9))
            0:       en = st - $urandom_range(1, 50);
            1, 2:    en = st;
            default: en = st + $urandom_range(0, 400);
         endcase
         add_insert(8'($urandom), st, en);
      end else if (pick < 90) begin
         time_base = time_base + $urandom_range(0, 150);
         add_tick(time_base);
      end else begin
         r.mode       = 1'($urandom);
         r.event_id   = 8'($urandom);
         r.start_time = $urandom;
         r.end_time   = $urandom;
         r.now        = $urandom;
         pending_reqs = {pending_reqs, r};
      end
   endtask

   task automatic run_set(input int idle_pct, input int stall_pct, input logic [31:0] base);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      time_base      = base;
      for (int i = 0; i < RANDOM_PER_SET; i++) add_random_item();
      while (pending_reqs.size() > 0 || req_valid) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) apply_to_shadow(req_data);
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure, including the one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (pressure_on && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            if (mismatches < REPORT_MAX)
               $display("unexpected beat: kind=%0d status=%0d id=%02h retired=%0d last=%0d",
                        rsp_data.kind, rsp_data.status, rsp_data.fired_id,
                        rsp_data.retired, rsp_data.last);
            mismatches++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.kind !== want.kind || rsp_data.status !== want.status ||
                rsp_data.fired_id !== want.fired_id || rsp_data.retired !== want.retired ||
                rsp_data.last !== want.last) begin
               if (mismatches < REPORT_MAX) begin
                  $write("mismatch: expected kind=%0d status=%0d id=%02h retired=%0d last=%0d,",
                         want.kind, want.status, want.fired_id, want.retired, want.last);
                  $display(" got kind=%0d status=%0d id=%02h retired=%0d last=%0d",
                           rsp_data.kind, rsp_data.status, rsp_data.fired_id,
                           rsp_data.retired, rsp_data.last);
               end
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty tick, extremes, equal starts, end before start, full store
      add_tick(32'hFFFF_FFFF);
      add_insert(8'h00, 32'h0000_0000, 32'h0000_0000);
      add_insert(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_insert(8'h01, 32'd100, 32'd50);
      add_insert(8'h02, 32'd100, 32'd200);
      add_insert(8'h03, 32'd100, 32'd100);
      add_tick(32'd0);
      add_tick(32'd50);
      add_tick(32'd100);
      for (int k = 0; k < 15; k++)
         add_insert(8'h10 + k[7:0], $urandom, $urandom);
      add_tick(32'hFFFF_FFFF);
      while (pending_reqs.size() > 0 || req_valid) @(posedge clock);

      run_set(0, 0, $urandom);
      run_set(86, 0, 32'hFFFF_F000);
      run_set(0, 86, $urandom);
      run_set(9, 9, $urandom);

      // long receiver hold-off while the sender keeps offering beats
      pressure_on = 1'b1;
      run_set(0, 0, $urandom);

      while (expected_rsps.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/toeq_pkg.sv
design/toeq_cell.sv
design/toeq_ctrl.sv
design/time_ordered_event_queue.sv
dv/time_ordered_event_queue_tb.sv
